### src/adcma_pkg.sv
// Package for the ADC temperature moving-average block.
// Holds field widths, fixed-point conversion constants, the sequencer state type
// and the ring control struct. No dependencies.
package adcma_pkg;

  // Default averaging window, in items
  localparam int unsigned WINDOW_DEF = 30;

  // Field widths
  localparam int unsigned CODE_W = 12;
  localparam int unsigned CEL_W  = 20;
  localparam int unsigned FAH_W  = 21;

  // Celsius in 1/256 degree is round(N / 1721), where N = 192631552 - 206250 * code.
  // Round half up: floor((2N + 1721) / 3442).
  // The dividend gets a bias of 2^19 * 3442 so that it stays positive. The biased
  // quotient then differs from the signed result only in its top bit.
  localparam int unsigned PROD_W  = 31;
  localparam int unsigned C_NUM_W = 32;
  localparam logic [18:0] C_SCALE = 19'd412500;                 // 2 * 206250
  localparam logic [C_NUM_W-1:0] C_BIAS = 32'd2189864121;       // 385264825 + 2^19*3442
  localparam int unsigned C_DIV   = 3442;

  // Fahrenheit is floor((18N + 2*8192*8605 + 8605) / 17210).
  // Here 18N = 9 * 2N, so the same product is reused.
  // The bias is 2^20 * 17210.
  localparam int unsigned F_NUM_W = 35;
  localparam logic [F_NUM_W-1:0] F_BIAS = 35'd21654353821;      // 3608360861 + 2^20*17210
  localparam int unsigned F_DIV   = 17210;

  // Average offsets, per window item: Celsius 1 + 2^20, Fahrenheit 81925 + 10 * 2^20
  localparam int unsigned CA_OFF_K = 1 + (1 << 20);
  localparam int unsigned FA_OFF_K = 81925 + 10 * (1 << 20);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV_NOW,
    ST_SUM,
    ST_AVG_LOAD,
    ST_DIV_AVG,
    ST_OUT
  } adcma_state_e;

  // Ring control: rd fetches the entry about to be replaced, upd writes it and
  // updates the running sum
  typedef struct packed {
    logic rd;
    logic upd;
  } ring_ctrl_t;

endpackage

### src/adcma_sdiv.sv
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// The dividend's low bits shift out of the quotient register as the quotient
// shifts in. Uses no package items.
module adcma_sdiv #(
  parameter int unsigned DEND_W  = 32,
  parameter int unsigned QUO_W   = 20,
  parameter int unsigned DIVISOR = 3442
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEND_W-1:0] dividend_i,
  output logic              busy_o,
  output logic [QUO_W-1:0]  quotient_o
);

  localparam int unsigned REM_W = $clog2(DIVISOR + 1);
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);
  localparam logic [REM_W:0] DSOR = (REM_W + 1)'(DIVISOR);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    trial;
  logic [DEND_W-1:0] upper;

  // Upper dividend part seeds the remainder. It is below the divisor by range.
  assign upper   = dividend_i >> QUO_W;
  assign shifted = {rem_q, quo_q[QUO_W-1]};
  assign trial   = shifted - DSOR;

  // Load, then step one quotient bit per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = upper[REM_W-1:0];
      quo_d = dividend_i[QUO_W-1:0];
      cnt_d = CNT_W'(QUO_W);
    end else if (cnt_q != '0) begin
      if (shifted >= DSOR) begin
        rem_d = trial[REM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[REM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Hold the step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift the datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

### src/adcma_ring.sv
// Sample ring, running sum, write slot and window-full flag.
// Depends on adcma_pkg for widths and the ring control struct.
module adcma_ring #(
  parameter int unsigned WINDOW = adcma_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = adcma_pkg::CEL_W + $clog2(WINDOW)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  adcma_pkg::ring_ctrl_t             ctrl_i,
  input  logic signed [adcma_pkg::CEL_W-1:0] c_now_i,
  output logic signed [SUM_W-1:0]           sum_o,
  output logic                              full_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic signed [adcma_pkg::CEL_W-1:0] ring_mem [WINDOW];
  logic signed [adcma_pkg::CEL_W-1:0] old_q;
  logic signed [adcma_pkg::CEL_W-1:0] drop;
  logic [SLOT_W-1:0]                  slot_q, slot_d;
  logic                               full_q, full_d;
  logic signed [SUM_W-1:0]            sum_q, sum_d;

  // Read the outgoing entry, write the new one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      old_q <= ring_mem[slot_q];
    end
    if (ctrl_i.upd) begin
      ring_mem[slot_q] <= c_now_i;
    end
  end

  // Drop the oldest value only once the ring has filled
  assign drop = full_q ? old_q : '0;

  // Advance slot, sum and fill flag
  always_comb begin
    slot_d = slot_q;
    full_d = full_q;
    sum_d  = sum_q;
    if (ctrl_i.upd) begin
      sum_d = sum_q + SUM_W'(c_now_i) - SUM_W'(drop);
      if (slot_q == LAST_SLOT) begin
        slot_d = '0;
        full_d = 1'b1;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      slot_q <= slot_d;
      full_q <= full_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign full_o = full_q;

  // Slot never passes the last ring entry
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("ring slot out of range");

  // Ring fills only on the write into the last slot
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> $past(ctrl_i.upd && (slot_q == LAST_SLOT)))
    else $error("ring full flag set without a write into the last slot");

endmodule

### src/adc_temperature_moving_average.sv
// Top level of the ADC temperature moving-average block: sequencer, code scaling,
// four bit-serial dividers, sample ring and output register.
// Depends on adcma_pkg, adcma_sdiv and adcma_ring.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_stall_o, adc_code_i   | sink
//   out     | out_valid_o, out_stall_i, celsius_*, | source
//           | fahrenheit_*, avg_valid_o            |
//
// Each item steps through the sequencer: capture and scale the code, run the two
// current-value dividers, update the ring, run the two average dividers and load
// the output. The two serial divider passes set the pace: one pass is for the
// current values and one is for the averages. The next item is accepted only once
// the sequencer is back in idle, after the result has been loaded.
// Reset clears the sequencer, ring slot, fill flag, running sum and output valid.
// A stalled result stays in the output register while the next item is
// accepted and worked on.
// in_stall_o is high from acceptance until the sequencer returns to idle.
module adc_temperature_moving_average #(
  parameter int unsigned WINDOW = adcma_pkg::WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [adcma_pkg::CODE_W-1:0]        adc_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [adcma_pkg::CEL_W-1:0]  celsius_now_o,
  output logic signed [adcma_pkg::FAH_W-1:0]  fahrenheit_now_o,
  output logic signed [adcma_pkg::CEL_W-1:0]  celsius_avg_o,
  output logic signed [adcma_pkg::FAH_W-1:0]  fahrenheit_avg_o,
  output logic                                avg_valid_o
);

  localparam int unsigned CEL_W = adcma_pkg::CEL_W;
  localparam int unsigned FAH_W = adcma_pkg::FAH_W;
  localparam int unsigned SUM_W = CEL_W + $clog2(WINDOW);
  localparam int unsigned DCA_W = SUM_W + 2;
  localparam int unsigned DFA_W = SUM_W + 5;
  localparam int unsigned EXT_W = DFA_W + 2;
  localparam logic signed [EXT_W-1:0] CA_OFF = EXT_W'(adcma_pkg::CA_OFF_K * WINDOW);
  localparam logic signed [EXT_W-1:0] FA_OFF = EXT_W'(adcma_pkg::FA_OFF_K * WINDOW);

  adcma_pkg::adcma_state_e state_q, state_d;
  adcma_pkg::ring_ctrl_t   ring_ctrl;

  logic                                code_load, prod_load, now_start, avg_start, out_load;
  logic [adcma_pkg::CODE_W-1:0]        code_q;
  logic [adcma_pkg::PROD_W-1:0]        prod_q;
  logic [adcma_pkg::C_NUM_W-1:0]       dend_c;
  logic [adcma_pkg::F_NUM_W-1:0]       dend_f;
  logic [adcma_pkg::F_NUM_W-1:0]       prod_f;
  logic                                busy_c, busy_f, busy_ca, busy_fa;
  logic [CEL_W-1:0]                    quo_c, quo_ca;
  logic [FAH_W-1:0]                    quo_f, quo_fa;
  logic signed [CEL_W-1:0]             c_now;
  logic signed [SUM_W-1:0]             sum;
  logic                                full;
  logic signed [EXT_W-1:0]             sum_x, ext_ca, ext_fa;
  logic [DCA_W-1:0]                    dend_ca;
  logic [DFA_W-1:0]                    dend_fa;
  logic                                out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      adcma_pkg::ST_IDLE:     if (in_valid_i) state_d = adcma_pkg::ST_MUL;
      adcma_pkg::ST_MUL:      state_d = adcma_pkg::ST_LOAD;
      adcma_pkg::ST_LOAD:     state_d = adcma_pkg::ST_DIV_NOW;
      adcma_pkg::ST_DIV_NOW:  if (!busy_c && !busy_f) state_d = adcma_pkg::ST_SUM;
      adcma_pkg::ST_SUM:      state_d = adcma_pkg::ST_AVG_LOAD;
      adcma_pkg::ST_AVG_LOAD: state_d = adcma_pkg::ST_DIV_AVG;
      adcma_pkg::ST_DIV_AVG:  if (!busy_ca && !busy_fa) state_d = adcma_pkg::ST_OUT;
      adcma_pkg::ST_OUT:      if (!out_valid_q || !out_stall_i) state_d = adcma_pkg::ST_IDLE;
      default:                state_d = adcma_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o    = 1'b1;
    code_load     = 1'b0;
    prod_load     = 1'b0;
    now_start     = 1'b0;
    avg_start     = 1'b0;
    out_load      = 1'b0;
    ring_ctrl.rd  = 1'b0;
    ring_ctrl.upd = 1'b0;
    unique case (state_q)
      adcma_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        code_load  = in_valid_i;
      end
      adcma_pkg::ST_MUL:      prod_load = 1'b1;
      adcma_pkg::ST_LOAD: begin
        now_start    = 1'b1;
        ring_ctrl.rd = 1'b1;
      end
      adcma_pkg::ST_DIV_NOW:  ;
      adcma_pkg::ST_SUM:      ring_ctrl.upd = 1'b1;
      adcma_pkg::ST_AVG_LOAD: avg_start = 1'b1;
      adcma_pkg::ST_DIV_AVG:  ;
      adcma_pkg::ST_OUT:      out_load = !out_valid_q || !out_stall_i;
      default:                ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adcma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the code, then scale it
  always_ff @(posedge clk_i) begin
    if (code_load) begin
      code_q <= adc_code_i;
    end
    if (prod_load) begin
      prod_q <= adcma_pkg::PROD_W'(code_q) * adcma_pkg::PROD_W'(adcma_pkg::C_SCALE);
    end
  end

  // Biased dividends for the current values; Fahrenheit uses nine times the product
  assign prod_f = adcma_pkg::F_NUM_W'(prod_q);
  assign dend_c = adcma_pkg::C_BIAS - adcma_pkg::C_NUM_W'(prod_q);
  assign dend_f = adcma_pkg::F_BIAS - (prod_f << 3) - prod_f;

  adcma_sdiv #(
    .DEND_W (adcma_pkg::C_NUM_W),
    .QUO_W  (CEL_W),
    .DIVISOR(adcma_pkg::C_DIV)
  ) u_div_c (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (now_start),
    .dividend_i(dend_c),
    .busy_o    (busy_c),
    .quotient_o(quo_c)
  );

  adcma_sdiv #(
    .DEND_W (adcma_pkg::F_NUM_W),
    .QUO_W  (FAH_W),
    .DIVISOR(adcma_pkg::F_DIV)
  ) u_div_f (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (now_start),
    .dividend_i(dend_f),
    .busy_o    (busy_f),
    .quotient_o(quo_f)
  );

  // Remove the bias by flipping the quotient's top bit
  assign c_now = {~quo_c[CEL_W-1], quo_c[CEL_W-2:0]};

  adcma_ring #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .c_now_i(c_now),
    .sum_o  (sum),
    .full_o (full)
  );

  // Biased dividends for the averages: 2S + offset and 18S + offset
  assign sum_x   = EXT_W'(sum);
  assign ext_ca  = (sum_x <<< 1) + CA_OFF;
  assign ext_fa  = (sum_x <<< 4) + (sum_x <<< 1) + FA_OFF;
  assign dend_ca = ext_ca[DCA_W-1:0];
  assign dend_fa = ext_fa[DFA_W-1:0];

  adcma_sdiv #(
    .DEND_W (DCA_W),
    .QUO_W  (CEL_W),
    .DIVISOR(2 * WINDOW)
  ) u_div_ca (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (avg_start),
    .dividend_i(dend_ca),
    .busy_o    (busy_ca),
    .quotient_o(quo_ca)
  );

  adcma_sdiv #(
    .DEND_W (DFA_W),
    .QUO_W  (FAH_W),
    .DIVISOR(10 * WINDOW)
  ) u_div_fa (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (avg_start),
    .dividend_i(dend_fa),
    .busy_o    (busy_fa),
    .quotient_o(quo_fa)
  );

  // Output register: load a finished item, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      celsius_now_o    <= c_now;
      fahrenheit_now_o <= {~quo_f[FAH_W-1], quo_f[FAH_W-2:0]};
      celsius_avg_o    <= full ? {~quo_ca[CEL_W-1], quo_ca[CEL_W-2:0]} : '0;
      fahrenheit_avg_o <= full ? {~quo_fa[FAH_W-1], quo_fa[FAH_W-2:0]} : '0;
      avg_valid_o      <= full;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result appears only from the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == adcma_pkg::ST_OUT))
    else $error("result raised outside the output state");

  // Averages read zero until the window has filled
  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !avg_valid_o) |-> (celsius_avg_o == '0) && (fahrenheit_avg_o == '0))
    else $error("nonzero average before the window filled");

  // No divider runs while the block waits for an item
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adcma_pkg::ST_IDLE) |-> !(busy_c || busy_f || busy_ca || busy_fa))
    else $error("divider busy in idle");

endmodule

### bench/adc_temperature_moving_average_tb.sv
// Testbench for adc_temperature_moving_average: ADC codes go in, and each result is
// checked against a built-in fixed-point predictor of the conversion and window average.
// Depends on adcma_pkg and the block's RTL.
module adc_temperature_moving_average_tb;

  localparam int CODE_W = adcma_pkg::CODE_W;
  localparam int CEL_W  = adcma_pkg::CEL_W;
  localparam int FAH_W  = adcma_pkg::FAH_W;
  localparam int WIN    = adcma_pkg::WINDOW_DEF;

  // Celsius in 1/256 degree is (CEL_K - code * CEL_PER_CODE) / CEL_DEN, exactly
  localparam longint CEL_DEN      = longint'(1721) * 27536;
  localparam longint CEL_K        = longint'(6912) * 1721 * 27536 +
                                    longint'(180736000) * 27536;
  localparam longint CEL_PER_CODE = longint'(3300000) * 1721;
  localparam longint FAH_OFFSET   = 8192;  // 32 degrees in 1/256 units

  typedef struct packed {
    logic [CEL_W-1:0] celsius_now;
    logic [FAH_W-1:0] fahrenheit_now;
    logic [CEL_W-1:0] celsius_avg;
    logic [FAH_W-1:0] fahrenheit_avg;
    logic             avg_valid;
  } temp_reading_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic [CODE_W-1:0]       adc_code_i  = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [CEL_W-1:0] celsius_now_o;
  logic signed [FAH_W-1:0] fahrenheit_now_o;
  logic signed [CEL_W-1:0] celsius_avg_o;
  logic signed [FAH_W-1:0] fahrenheit_avg_o;
  logic                    avg_valid_o;

  // Predictor state: Celsius ring, next slot, fill flag and running sum
  longint      celsius_ring [WIN];
  int unsigned ring_slot = 0;
  bit          ring_full = 1'b0;
  longint      celsius_sum = 0;

  temp_reading_t pending_readings[$];
  int send_idle_pct  = 31;
  int recv_stall_pct = 51;
  int mismatches     = 0;
  int codes_sent     = 0;
  int readings_seen  = 0;
  int averages_seen  = 0;

  adc_temperature_moving_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .adc_code_i      (adc_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .celsius_now_o   (celsius_now_o),
    .fahrenheit_now_o(fahrenheit_now_o),
    .celsius_avg_o   (celsius_avg_o),
    .fahrenheit_avg_o(fahrenheit_avg_o),
    .avg_valid_o     (avg_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor(num / den + 1/2) for den > 0
  function automatic longint round_half_up(input longint num, input longint den);
    longint twice;
    longint dd;
    twice = 2 * num + den;
    dd    = 2 * den;
    if (twice >= 0) return twice / dd;
    return -((-twice + dd - 1) / dd);
  endfunction

  // Convert one code, push it into the ring and return the expected result
  function automatic temp_reading_t predict_reading(input logic [CODE_W-1:0] code);
    temp_reading_t r;
    longint        num;
    longint        c_now;
    num              = CEL_K - longint'(code) * CEL_PER_CODE;
    c_now            = round_half_up(num, CEL_DEN);
    r.celsius_now    = c_now[CEL_W-1:0];
    r.fahrenheit_now = FAH_W'(round_half_up(num * 9 + FAH_OFFSET * 5 * CEL_DEN,
                                            5 * CEL_DEN));
    // Drop the oldest value only once the ring has wrapped
    if (ring_full) celsius_sum -= celsius_ring[ring_slot];
    celsius_ring[ring_slot] = c_now;
    celsius_sum += c_now;
    ring_slot++;
    if (ring_slot == WIN) begin
      ring_slot = 0;
      ring_full = 1'b1;
    end
    r.avg_valid      = ring_full;
    r.celsius_avg    = '0;
    r.fahrenheit_avg = '0;
    if (ring_full) begin
      r.celsius_avg    = CEL_W'(round_half_up(celsius_sum, WIN));
      r.fahrenheit_avg = FAH_W'(round_half_up(celsius_sum * 9 + FAH_OFFSET * 5 * WIN,
                                              5 * WIN));
    end
    return r;
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_code(input logic [CODE_W-1:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      adc_code_i <= CODE_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(predict_reading(code));
    codes_sent++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] expected,
                             input logic signed [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Check each accepted result against the oldest prediction, then pick the next stall
  always @(posedge clk_i) begin : result_check
    temp_reading_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $error("result with no item pending: celsius_now %0d", celsius_now_o);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("celsius_now", $signed(want.celsius_now), celsius_now_o);
        check_field("fahrenheit_now", $signed(want.fahrenheit_now), fahrenheit_now_o);
        check_field("celsius_avg", $signed(want.celsius_avg), celsius_avg_o);
        check_field("fahrenheit_avg", $signed(want.fahrenheit_avg), fahrenheit_avg_o);
        check_field("avg_valid", {31'b0, want.avg_valid}, {31'b0, avg_valid_o});
        readings_seen++;
        if (want.avg_valid) averages_seen++;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Full-scale codes and walking ones, all while the window is still filling
  task automatic test_extreme_codes();
    send_code(12'h000);
    send_code(12'hFFF);
    send_code(12'hFFE);
    send_code(12'h7FF);
    send_code(12'd876);  // close to room temperature
    for (int b = 0; b < CODE_W; b++) send_code(CODE_W'(1) << b);
  endtask

  // Finish filling the ring so that the first valid average comes out
  task automatic test_first_average();
    while (!ring_full) send_code(CODE_W'($urandom));
  endtask

  // Whole windows at each end of the scale, then alternating ends
  task automatic test_full_scale_windows();
    repeat (WIN) send_code(12'h000);
    repeat (WIN) send_code(12'hFFF);
    for (int i = 0; i < WIN; i++) send_code(i[0] ? 12'hFFF : 12'h000);
  endtask

  // Mix of a slow drift like a real sensor, uniform codes and full-scale spikes
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    int level;
    int pick;
    logic [CODE_W-1:0] code;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    level = 876;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        code = CODE_W'($urandom_range(0, 4095));
      end else if (pick < 9) begin
        level = level + int'($urandom_range(0, 32)) - 16;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        code = CODE_W'(level);
      end else begin
        code = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
      send_code(code);
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_codes();
    test_first_average();
    test_full_scale_windows();
    test_random_traffic(31, 51, 495);
    test_random_traffic(51, 31, 495);
    test_random_traffic(0, 0, 495);
    in_valid_i <= 1'b0;

    // Drain the pending results, then watch for strays
    waited = 0;
    while (pending_readings.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_readings.size() != 0) begin
      $error("%0d results never arrived", pending_readings.size());
      mismatches++;
    end
    repeat (120) @(posedge clk_i);

    $display("Sent %0d ADC codes, checked %0d results, %0d with a full window.",
             codes_sent, readings_seen, averages_seen);
    $display("Idling covered sender-heavy, receiver-heavy and back-to-back traffic.");
    if (mismatches == 0) begin
      $display("adc_temperature_moving_average_tb OK");
    end else begin
      $display("adc_temperature_moving_average_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("adc_temperature_moving_average_tb NOT OK");
    $finish;
  end

endmodule
